### src/hmmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmmd_pkg: shared types and constants of the memory map decoder
// Region codes, opcodes, register indexes, bus address map and word layouts.
// ----------------------------------------------------------------------------
package hmmd_pkg;

	// default sizes
	localparam int WORK_RAM_BYTES_DEF = 8192;
	localparam int WATCH_SLOTS_DEF    = 4;
	localparam int HIGH_PAGE_BYTES    = 256;
	localparam int CFG_INDEX_W        = 3;
	localparam int CFG_DATA_W         = 16;

	// bus address map (region start addresses)
	localparam logic [15:0] VRAM_BASE    = 16'h8000;
	localparam logic [15:0] CART_HI_BASE = 16'hA000;
	localparam logic [15:0] WRAM_START   = 16'hC000;
	localparam logic [15:0] OAM_BASE     = 16'hFE00;
	localparam logic [15:0] BAD_BASE     = 16'hFEA0;
	localparam logic [15:0] HIGH_BASE    = 16'hFF00;

	// special registers in the high page
	localparam logic [15:0] DIV_ADDR = 16'hFF04;
	localparam logic [15:0] DMA_ADDR = 16'hFF46;

	// watch new value reported for reads
	localparam logic [15:0] READ_MARK = 16'hFFFF;

	// opcodes
	localparam logic [1:0] OP_READ_BYTE  = 2'd0;
	localparam logic [1:0] OP_READ_WORD  = 2'd1;
	localparam logic [1:0] OP_WRITE_BYTE = 2'd2;
	localparam logic [1:0] OP_UNUSED     = 2'd3;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_WATCH_EN = 3'd4;

	typedef enum logic [2:0] {
		TGT_WRAM = 3'd0,
		TGT_HIGH = 3'd1,
		TGT_CART = 3'd2,
		TGT_VRAM = 3'd3,
		TGT_OAM  = 3'd4,
		TGT_BAD  = 3'd5
	} region_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic        watch;
	} req_word_t;

	typedef struct packed {
		region_t     target;
		logic [15:0] forward_address;
		logic [7:0]  forward_data;
		logic        forward_wide;
		logic [15:0] read_data;
		logic        dma_start;
		logic [15:0] dma_source;
		logic        watch_hit;
		logic [7:0]  watch_old_value;
		logic [15:0] watch_new_value;
	} rsp_word_t;

	// decode results handed from the decoder to the pipeline
	typedef struct packed {
		region_t region;
		logic    hit;
		logic    div_reg;
		logic    dma_reg;
	} dec_info_t;

endpackage
`default_nettype wire

### src/hmmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmmd_if: request and response channels of the memory map decoder
// Valid/ready channels; a word moves at an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface hmmd_req_if;
	import hmmd_pkg::*;
	logic      valid;
	logic      ready;
	req_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hmmd_rsp_if;
	import hmmd_pkg::*;
	logic      valid;
	logic      ready;
	rsp_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/handheld_memory_map_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// handheld_memory_map_decoder_unit: 16-bit bus memory map decoder
// Decodes accesses, serves work RAM and high page, forwards cart, VRAM and OAM.
// ----------------------------------------------------------------------------
// One request word gives one response word. A request is decoded and both
// bytes of a word are read from the local store at acceptance; when stage 1
// moves on, the write is done and the response goes to the output register,
// which drives rsp.valid. Throughput is one request per cycle while the
// response side keeps taking words. A write followed at once by a read of the
// same byte is bypassed around the store's registered read. After reset a
// clearing pass zeroes both stores over all WORK_RAM_BYTES indexes (8192 by
// default) before the first request is taken; configuration writes are taken during the pass.
module handheld_memory_map_decoder_unit import hmmd_pkg::*; #(
	parameter int WORK_RAM_BYTES = WORK_RAM_BYTES_DEF,
	parameter int WATCH_SLOTS    = WATCH_SLOTS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	hmmd_req_if.sink                    req,
	hmmd_rsp_if.source                  rsp
);

	localparam int          AW       = $clog2(WORK_RAM_BYTES);
	localparam logic [AW-1:0] CLR_LAST = AW'(WORK_RAM_BYTES - 1);

	// configuration
	logic [WATCH_SLOTS-1:0][15:0] watch_addr_q;
	logic [3:0]                   watch_en_q;

	// clearing pass
	logic          clr_q;
	logic [AW-1:0] clr_idx_q;

	// decode
	dec_info_t     info;
	logic [AW-1:0] widx0, widx1;
	logic [7:0]    hidx0, hidx1;

	// stage 1
	logic          v_s1;
	req_word_t     req_s1;
	dec_info_t     info_s1;
	logic [AW-1:0] widx0_s1, widx1_s1;
	logic [7:0]    hidx0_s1, hidx1_s1;

	// bypass of the write done at the read edge
	logic          fwd_v_q;
	logic          fwd_hi_q;
	logic [AW-1:0] fwd_widx_q;
	logic [7:0]    fwd_hidx_q;
	logic [7:0]    fwd_data_q;

	// output register
	logic      out_v_q;
	rsp_word_t out_q;

	// store ports
	logic          accept;
	logic          s1_go;
	logic          wr_wram, wr_high;
	logic [7:0]    high_wdata;
	logic          wram_we, high_we;
	logic [AW-1:0] wram_waddr;
	logic [7:0]    wram_wd;
	logic [7:0]    high_waddr;
	logic [7:0]    high_wd;
	logic [7:0]    wram_rd0, wram_rd1, high_rd0, high_rd1;
	logic [7:0]    wb0, wb1, hb0, hb1, b0, b1;
	rsp_word_t     res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watch_addr_q <= '0;
			watch_en_q   <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_WATCH_EN) begin
				watch_en_q <= cfg_data[3:0];
			end
			for (int i = 0; i < WATCH_SLOTS; i++) begin
				if (cfg_index == CFG_INDEX_W'(i)) begin
					watch_addr_q[i] <= cfg_data;
				end
			end
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			if (clr_idx_q == CLR_LAST) begin
				clr_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + AW'(1);
		end
	end

	hmmd_decode #(
		.WORK_RAM_BYTES (WORK_RAM_BYTES),
		.WATCH_SLOTS    (WATCH_SLOTS)
	) u_decode (
		.req        (req.data),
		.watch_addr (watch_addr_q),
		.watch_en   (watch_en_q),
		.info       (info),
		.widx0      (widx0),
		.widx1      (widx1),
		.hidx0      (hidx0),
		.hidx1      (hidx1)
	);

	// handshake
	assign s1_go     = v_s1 && (!out_v_q || rsp.ready);
	assign req.ready = !clr_q && (!v_s1 || s1_go);
	assign accept    = req.valid && req.ready;

	// store writes of stage 1; divider write leaves zero behind
	assign wr_wram    = s1_go && req_s1.opcode == OP_WRITE_BYTE && info_s1.region == TGT_WRAM;
	assign wr_high    = s1_go && req_s1.opcode == OP_WRITE_BYTE && info_s1.region == TGT_HIGH;
	assign high_wdata = info_s1.div_reg ? 8'd0 : req_s1.write_data;

	assign wram_we    = clr_q || wr_wram;
	assign wram_waddr = clr_q ? clr_idx_q : widx0_s1;
	assign wram_wd    = clr_q ? 8'd0 : req_s1.write_data;
	assign high_we    = clr_q || wr_high;
	assign high_waddr = clr_q ? clr_idx_q[7:0] : hidx0_s1;
	assign high_wd    = clr_q ? 8'd0 : high_wdata;

	hmmd_store #(.DEPTH (WORK_RAM_BYTES)) u_wram (
		.clk    (clk),
		.we     (wram_we),
		.waddr  (wram_waddr),
		.wdata  (wram_wd),
		.re     (accept),
		.raddr0 (widx0),
		.raddr1 (widx1),
		.rdata0 (wram_rd0),
		.rdata1 (wram_rd1)
	);

	hmmd_store #(.DEPTH (HIGH_PAGE_BYTES)) u_high (
		.clk    (clk),
		.we     (high_we),
		.waddr  (high_waddr),
		.wdata  (high_wd),
		.re     (accept),
		.raddr0 (hidx0),
		.raddr1 (hidx1),
		.rdata0 (high_rd0),
		.rdata1 (high_rd1)
	);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			fwd_v_q <= 1'b0;
		end else if (accept) begin
			v_s1    <= 1'b1;
			fwd_v_q <= wr_wram || wr_high;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	// stage 1 payload and bypass capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1     <= req.data;
			info_s1    <= info;
			widx0_s1   <= widx0;
			widx1_s1   <= widx1;
			hidx0_s1   <= hidx0;
			hidx1_s1   <= hidx1;
			fwd_hi_q   <= wr_high;
			fwd_widx_q <= widx0_s1;
			fwd_hidx_q <= hidx0_s1;
			fwd_data_q <= wr_high ? high_wdata : req_s1.write_data;
		end
	end

	// read data with bypass of the write that landed at the read edge
	always_comb begin
		wb0 = (fwd_v_q && !fwd_hi_q && fwd_widx_q == widx0_s1) ? fwd_data_q : wram_rd0;
		wb1 = (fwd_v_q && !fwd_hi_q && fwd_widx_q == widx1_s1) ? fwd_data_q : wram_rd1;
		hb0 = (fwd_v_q && fwd_hi_q && fwd_hidx_q == hidx0_s1) ? fwd_data_q : high_rd0;
		hb1 = (fwd_v_q && fwd_hi_q && fwd_hidx_q == hidx1_s1) ? fwd_data_q : high_rd1;
		b0  = (info_s1.region == TGT_HIGH) ? hb0 : wb0;
		b1  = (info_s1.region == TGT_HIGH) ? hb1 : wb1;
	end

	// response word
	always_comb begin
		res        = '0;
		res.target = info_s1.region;
		case (info_s1.region)
			TGT_CART, TGT_VRAM, TGT_OAM: begin
				res.forward_address = req_s1.address;
				if (req_s1.opcode == OP_WRITE_BYTE) begin
					res.forward_data = req_s1.write_data;
				end
				res.forward_wide = (req_s1.opcode == OP_READ_WORD);
			end
			TGT_WRAM, TGT_HIGH: begin
				if (req_s1.opcode == OP_READ_BYTE) begin
					res.read_data = {8'd0, b0};
				end else if (req_s1.opcode == OP_READ_WORD) begin
					res.read_data = {b1, b0};
				end
				if (info_s1.region == TGT_HIGH && info_s1.dma_reg
						&& req_s1.opcode == OP_WRITE_BYTE) begin
					res.dma_start  = 1'b1;
					res.dma_source = {req_s1.write_data, 8'd0};
				end
				if (info_s1.hit) begin
					res.watch_old_value = b0;
				end
			end
			default: begin
			end
		endcase
		if (info_s1.hit) begin
			res.watch_hit       = 1'b1;
			res.watch_new_value = (req_s1.opcode == OP_WRITE_BYTE)
				? {8'd0, req_s1.write_data} : READ_MARK;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_go) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_q <= res;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

endmodule
`default_nettype wire

### src/hmmd_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmmd_store: byte memory, one write port and two registered read ports
// Used for work RAM and the high page.
// ----------------------------------------------------------------------------
module hmmd_store #(
	parameter  int DEPTH = 256,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr0,
	input  wire logic [AW-1:0] raddr1,
	output logic      [7:0]    rdata0,
	output logic      [7:0]    rdata1
);

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports, registered on re; data valid in the cycle after re
	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule
`default_nettype wire

### src/hmmd_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmmd_decode: address decode and watch slot compare
// Region, store indexes for both bytes of a word, special registers, hit.
// ----------------------------------------------------------------------------
module hmmd_decode import hmmd_pkg::*; #(
	parameter  int WORK_RAM_BYTES = WORK_RAM_BYTES_DEF,
	parameter  int WATCH_SLOTS    = WATCH_SLOTS_DEF,
	localparam int AW             = $clog2(WORK_RAM_BYTES)
) (
	input  wire req_word_t                        req,
	input  wire logic [WATCH_SLOTS-1:0][15:0]     watch_addr,
	input  wire logic [3:0]                       watch_en,
	output dec_info_t                             info,
	output logic      [AW-1:0]                    widx0,
	output logic      [AW-1:0]                    widx1,
	output logic      [7:0]                       hidx0,
	output logic      [7:0]                       hidx1
);

	localparam logic [15:0] WR_SIZE = 16'(WORK_RAM_BYTES);

	region_t     region;
	logic        hit;
	logic [15:0] off;
	logic [15:0] k0;
	logic [15:0] k1;

	// region decode
	always_comb begin
		if (req.address < VRAM_BASE) begin
			region = TGT_CART;
		end else if (req.address < CART_HI_BASE) begin
			region = TGT_VRAM;
		end else if (req.address < WRAM_START) begin
			region = TGT_CART;
		end else if (req.address < OAM_BASE) begin
			region = TGT_WRAM;
		end else if (req.address < BAD_BASE) begin
			region = TGT_OAM;
		end else if (req.address < HIGH_BASE) begin
			region = TGT_BAD;
		end else begin
			region = TGT_HIGH;
		end
	end

	// work ram index: work ram and its echo both sit on 8 KiB boundaries, so
	// the offset is the low 13 bits; it stays below twice the store size
	always_comb begin
		off = {3'b000, req.address[12:0]};
		k0  = (off >= WR_SIZE) ? off - WR_SIZE : off;
		k1  = (k0 + 16'd1 == WR_SIZE) ? 16'd0 : k0 + 16'd1;
	end

	assign widx0 = k0[AW-1:0];
	assign widx1 = k1[AW-1:0];
	assign hidx0 = req.address[7:0];
	assign hidx1 = req.address[7:0] + 8'd1;

	// watch compare, first enabled match is enough
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < WATCH_SLOTS; i++) begin
			if (watch_en[i] && watch_addr[i] == req.address) begin
				hit = 1'b1;
			end
		end
	end

	always_comb begin
		info.region  = (req.opcode == OP_UNUSED) ? TGT_BAD : region;
		info.hit     = req.watch && hit && (req.opcode != OP_UNUSED);
		info.div_reg = (req.address == DIV_ADDR);
		info.dma_reg = (req.address == DMA_ADDR);
	end

endmodule
`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the handheld memory map decoder
// Drives byte reads, word reads, byte writes and the unused opcode over the whole 16-bit map,
// predicts each response word from a local copy of work RAM, the high page
// and the watch registers, and compares every field in order of arrival.
// ----------------------------------------------------------------------------
module tb_top import hmmd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WRAM_BYTES   = WORK_RAM_BYTES_DEF;
	localparam int WATCH_SLOTS  = WATCH_SLOTS_DEF;
	localparam int IDLE_LIMIT   = 50000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES       = 5;
	localparam int PHASE_WORDS  = 400;

	localparam logic [15:0] ECHO_BASE  = 16'hE000;
	localparam logic [15:0] ECHO_SHIFT = 16'h2000;

	localparam logic [CFG_INDEX_W-1:0] CFG_WATCH_ADDR_0 = 3'd0;

	// ------------------------------------------------------------------
	// Predictor and store of expected response words
	// ------------------------------------------------------------------
	class decode_scoreboard;
		bit [7:0]  wram[WRAM_BYTES];
		bit [7:0]  hpage[HIGH_PAGE_BYTES];
		bit [15:0] watch_addr[4];
		bit [3:0]  watch_en;
		rsp_word_t pending_rsp[$];
		int        errors;

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
			if (idx < CFG_WATCH_EN)
				watch_addr[idx] = val;
			else if (idx == CFG_WATCH_EN)
				watch_en = val[3:0];
		endfunction

		function region_t region_of(logic [15:0] a);
			if (a < VRAM_BASE) return TGT_CART;
			if (a < CART_HI_BASE) return TGT_VRAM;
			if (a < WRAM_START) return TGT_CART;
			if (a < OAM_BASE) return TGT_WRAM;
			if (a < BAD_BASE) return TGT_OAM;
			if (a < HIGH_BASE) return TGT_BAD;
			return TGT_HIGH;
		endfunction

		// echo folds down onto work RAM, then the offset wraps at the store size
		function int wram_slot(logic [15:0] a);
			int off;
			off = (a >= ECHO_BASE) ? int'(a) - int'(ECHO_SHIFT) : int'(a);
			return (off - int'(WRAM_START)) % WRAM_BYTES;
		endfunction

		function logic [7:0] local_byte(logic [15:0] a);
			case (region_of(a))
				TGT_WRAM: return wram[wram_slot(a)];
				TGT_HIGH: return hpage[a[7:0]];
				default:  return 8'h00;
			endcase
		endfunction

		// work out the response for one accepted request and update the stores
		function void note_request(req_word_t rq);
			rsp_word_t e;
			logic [15:0] a;
			int k;
			e = '0;
			a = rq.address;
			e.target = region_of(a);
			if (rq.opcode == OP_UNUSED) begin
				e.target = TGT_BAD;
			end else begin
				// watch compare sees the store before this access
				if (rq.watch) begin
					for (int s = 0; s < WATCH_SLOTS; s++) begin
						if (!e.watch_hit && watch_en[s] && watch_addr[s] == a) begin
							e.watch_hit = 1'b1;
							e.watch_old_value = local_byte(a);
							e.watch_new_value = (rq.opcode == OP_WRITE_BYTE) ?
								{8'h00, rq.write_data} : READ_MARK;
						end
					end
				end
				case (e.target)
					TGT_CART, TGT_VRAM, TGT_OAM: begin
						e.forward_address = a;
						if (rq.opcode == OP_WRITE_BYTE) e.forward_data = rq.write_data;
						if (rq.opcode == OP_READ_WORD) e.forward_wide = 1'b1;
					end
					TGT_WRAM: begin
						k = wram_slot(a);
						if (rq.opcode == OP_WRITE_BYTE) begin
							wram[k] = rq.write_data;
						end else begin
							e.read_data[7:0] = wram[k];
							if (rq.opcode == OP_READ_WORD)
								e.read_data[15:8] = wram[(k + 1) % WRAM_BYTES];
						end
					end
					TGT_HIGH: begin
						k = a[7:0];
						if (rq.opcode == OP_WRITE_BYTE) begin
							hpage[k] = rq.write_data;
							if (a == DIV_ADDR) begin
								hpage[DIV_ADDR[7:0]] = 8'h00;
							end else if (a == DMA_ADDR) begin
								e.dma_start = 1'b1;
								e.dma_source = {rq.write_data, 8'h00};
							end
						end else begin
							e.read_data[7:0] = hpage[k];
							if (rq.opcode == OP_READ_WORD)
								e.read_data[15:8] = hpage[(k + 1) % HIGH_PAGE_BYTES];
						end
					end
					default: ;
				endcase
			end
			pending_rsp.push_back(e);
		endfunction

		function void check_field(string fname, logic [15:0] exp_v, logic [15:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s expected %h got %h", $time, fname, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_response(rsp_word_t got);
			rsp_word_t e;
			if (pending_rsp.size() == 0) begin
				$display("%0t: response word with nothing pending: %p", $time, got);
				errors++;
				return;
			end
			e = pending_rsp.pop_front();
			check_field("target", e.target, got.target);
			check_field("forward_address", e.forward_address, got.forward_address);
			check_field("forward_data", e.forward_data, got.forward_data);
			check_field("forward_wide", e.forward_wide, got.forward_wide);
			check_field("read_data", e.read_data, got.read_data);
			check_field("dma_start", e.dma_start, got.dma_start);
			check_field("dma_source", e.dma_source, got.dma_source);
			check_field("watch_hit", e.watch_hit, got.watch_hit);
			check_field("watch_old_value", e.watch_old_value, got.watch_old_value);
			check_field("watch_new_value", e.watch_new_value, got.watch_new_value);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	bit                     tx_burst;
	bit                     rx_burst;
	int                     idle_cycles;
	decode_scoreboard       sb;

	hmmd_req_if req_ch ();
	hmmd_rsp_if rsp_ch ();

	handheld_memory_map_decoder_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	function automatic req_word_t mk_req(logic [1:0] op, logic [15:0] a, logic [7:0] d,
			logic wt);
		req_word_t w;
		w.opcode = op;
		w.address = a;
		w.write_data = d;
		w.watch = wt;
		return w;
	endfunction

	// valid is left high after the word is taken; a zero gap keeps it high
	task automatic send_word(req_word_t w);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.data = w;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		req_ch.valid = 1'b0;
		while (sb.pending_rsp.size() != 0) @(negedge clk);
	endtask

	// back-to-back register writes, we dropped after the last one
	task automatic write_regs(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2,
			logic [15:0] a3, logic [3:0] mask);
		logic [15:0] vals[5];
		vals = '{a0, a1, a2, a3, {12'h000, mask}};
		for (int i = 0; i < 5; i++) begin
			cfg_we = 1'b1;
			cfg_index = CFG_WATCH_ADDR_0 + i[CFG_INDEX_W-1:0];
			cfg_data = vals[i];
			sb.set_reg(cfg_index, cfg_data);
			@(negedge clk);
		end
		cfg_we = 1'b0;
	endtask

	function automatic logic [15:0] interesting_addr();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return WRAM_START + 16'($urandom_range(0, 31));
			3: return ECHO_BASE + 16'($urandom_range(0, 31));
			4: return HIGH_BASE + 16'($urandom_range(0, 255));
			5: return $urandom_range(0, 1) ? DIV_ADDR : DMA_ADDR;
			6: return OAM_BASE + 16'($urandom_range(0, 255));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// mostly local addresses in small windows so reads find earlier writes
	function automatic logic [15:0] pick_address();
		case ($urandom_range(0, 15))
			0, 1, 2, 3, 4: return WRAM_START + 16'($urandom_range(0, 31));
			5:       return 16'hDFE0 + 16'($urandom_range(0, 31));
			6:       return ECHO_BASE + 16'($urandom_range(0, 31));
			7:       return 16'hFDE0 + 16'($urandom_range(0, 31));
			8, 9:    return HIGH_BASE + 16'($urandom_range(0, 255));
			10:      return $urandom_range(0, 1) ? DIV_ADDR : DMA_ADDR;
			11:      return sb.watch_addr[$urandom_range(0, 3)];
			12:      return OAM_BASE + 16'($urandom_range(0, 255));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic req_word_t rand_request();
		int r;
		logic [1:0] op;
		r = $urandom_range(0, 99);
		if (r < 40) op = OP_WRITE_BYTE;
		else if (r < 70) op = OP_READ_BYTE;
		else if (r < 97) op = OP_READ_WORD;
		else op = OP_UNUSED;
		return mk_req(op, pick_address(), 8'($urandom_range(0, 255)),
			$urandom_range(0, 3) != 0);
	endfunction

	// ------------------------------------------------------------------
	// Response side: random per-word stall, none in bursts
	// ------------------------------------------------------------------
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = rx_burst ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// ------------------------------------------------------------------
	// Monitors and watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
			if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		sb = new;
		idle_cycles = 0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: region edges, store wrap, echo, divider, DMA, watch hits
		write_regs(WRAM_START, DMA_ADDR, 16'h9FFF, BAD_BASE, 4'hF);
		send_word(mk_req(OP_WRITE_BYTE, WRAM_START, 8'hA5, 1'b1));
		send_word(mk_req(OP_READ_BYTE, WRAM_START, 8'h00, 1'b1));
		send_word(mk_req(OP_WRITE_BYTE, 16'hDFFF, 8'h3C, 1'b0));
		send_word(mk_req(OP_READ_WORD, 16'hDFFF, 8'h00, 1'b0));
		send_word(mk_req(OP_READ_WORD, ECHO_BASE, 8'h00, 1'b0));
		send_word(mk_req(OP_WRITE_BYTE, 16'hFDFF, 8'h77, 1'b0));
		send_word(mk_req(OP_READ_WORD, 16'hFDFE, 8'h00, 1'b0));
		send_word(mk_req(OP_READ_BYTE, 16'h0000, 8'h00, 1'b0));
		send_word(mk_req(OP_READ_WORD, 16'h7FFF, 8'h00, 1'b0));
		send_word(mk_req(OP_WRITE_BYTE, VRAM_BASE, 8'hFF, 1'b0));
		send_word(mk_req(OP_READ_BYTE, 16'h9FFF, 8'h00, 1'b1));
		send_word(mk_req(OP_READ_WORD, CART_HI_BASE, 8'h00, 1'b0));
		send_word(mk_req(OP_WRITE_BYTE, 16'hBFFF, 8'h01, 1'b0));
		send_word(mk_req(OP_WRITE_BYTE, OAM_BASE, 8'h5E, 1'b0));
		send_word(mk_req(OP_READ_WORD, 16'hFE9F, 8'h00, 1'b0));
		send_word(mk_req(OP_WRITE_BYTE, BAD_BASE, 8'h12, 1'b1));
		send_word(mk_req(OP_READ_BYTE, BAD_BASE, 8'h00, 1'b1));
		send_word(mk_req(OP_READ_WORD, 16'hFEFF, 8'h00, 1'b0));
		send_word(mk_req(OP_WRITE_BYTE, HIGH_BASE, 8'h81, 1'b0));
		send_word(mk_req(OP_WRITE_BYTE, 16'hFFFF, 8'h5A, 1'b0));
		send_word(mk_req(OP_READ_WORD, 16'hFFFF, 8'h00, 1'b0));
		send_word(mk_req(OP_WRITE_BYTE, DIV_ADDR, 8'h99, 1'b0));
		send_word(mk_req(OP_READ_BYTE, DIV_ADDR, 8'h00, 1'b0));
		send_word(mk_req(OP_WRITE_BYTE, DMA_ADDR, 8'hFF, 1'b1));
		send_word(mk_req(OP_READ_WORD, DMA_ADDR, 8'h00, 1'b1));
		send_word(mk_req(OP_UNUSED, WRAM_START, 8'hC3, 1'b1));
		wait_drain();

		// random phases, each under its own watch setting
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: write_regs(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 4'h0);
				1: write_regs(16'h0000, 16'hFFFF, 16'hDFFF, DIV_ADDR, 4'hF);
				2: write_regs(interesting_addr(), interesting_addr(), interesting_addr(),
					interesting_addr(), 4'($urandom_range(1, 15)));
				3: write_regs(ECHO_BASE, WRAM_START, OAM_BASE, DMA_ADDR, 4'hF);
				default: write_regs(interesting_addr(), interesting_addr(),
					interesting_addr(), interesting_addr(), 4'b0101);
			endcase
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 100 == 0) begin
					tx_burst = ($urandom_range(0, 3) == 0);
					rx_burst = ($urandom_range(0, 3) == 0);
				end
				// sender holds off until the pipe is empty once mid-run
				if (phase == 2 && n == PHASE_WORDS / 2) wait_drain();
				send_word(rand_request());
			end
			wait_drain();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
